// ----- sv/ultrasonic_range_sampler_defines.svh -----
// Assertion macros shared by the ultrasonic range sampler RTL.
`ifndef ULTRASONIC_RANGE_SAMPLER_DEFINES_SVH
`define ULTRASONIC_RANGE_SAMPLER_DEFINES_SVH

// Same-cycle implication, inactive while reset is asserted.
`define URS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define URS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/urs_pkg.sv -----
// Types, constants and helpers for the ultrasonic range sampler.
package urs_pkg;

    localparam int unsigned TrigW  = 10;
    localparam int unsigned IntvW  = 20;
    localparam int unsigned TickW  = 24;
    localparam int unsigned ScaleW = 16;
    localparam int unsigned DistW  = 16;
    localparam int unsigned CfgW   = 24;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [TrigW-1:0]  TrigReset    = 10'd11;
    localparam logic [IntvW-1:0]  IntvReset    = 20'd51000;
    localparam logic [TickW-1:0]  TimeoutReset = 24'd1000000;
    localparam logic [ScaleW-1:0] ScaleReset   = 16'd1124;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TRIGGER  = 2'd0,
        CFG_INTERVAL = 2'd1,
        CFG_TIMEOUT  = 2'd2,
        CFG_SCALE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG      = 3'd1,
        PH_WAIT_LOW  = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_MEASURE   = 3'd4
    } t_phase;

    // Increment that sticks at the all-ones value.
    function automatic logic [TickW-1:0] sat_inc24(input logic [TickW-1:0] v);
        sat_inc24 = (&v) ? v : v + TickW'(1);
    endfunction

endpackage

// ----- sv/ultrasonic_range_sampler.sv -----
// Ultrasonic range sampler: trigger/echo sequencing and averaged distance.
// The result of an input transfer appears in the output register in the next cycle.
// Throughput: one tick per cycle; the whole step, including the 24x16 scale
// multiply and the averaging add, is one combinational pass between registers.
// A new tick is taken while a result waits, as long as that result leaves too.
// Reset (synchronous, active low) restores the register defaults, idles the
// sequencer with the interval elapsed and clears the stored distance.
`include "ultrasonic_range_sampler_defines.svh"

module ultrasonic_range_sampler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_echo_level,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_trigger_level,
    output logic [urs_pkg::DistW-1:0]        o_distance_cm,
    output logic                             o_updated,
    output logic                             o_no_echo,
    input  logic                             i_cfg_we,
    input  logic [urs_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [urs_pkg::CfgW-1:0]         i_cfg_data
);

    localparam int unsigned ProdW = urs_pkg::TickW + urs_pkg::ScaleW;

    // Configuration registers
    logic [urs_pkg::TrigW-1:0]  r_trigger_us;
    logic [urs_pkg::IntvW-1:0]  r_interval_us;
    logic [urs_pkg::TickW-1:0]  r_timeout_us;
    logic [urs_pkg::ScaleW-1:0] r_scale_q16;

    // Sequencer state
    urs_pkg::t_phase            r_phase, n_phase;
    logic [urs_pkg::TickW-1:0]  r_phase_ticks, n_phase_ticks;
    logic [urs_pkg::IntvW-1:0]  r_since, n_since;
    logic [urs_pkg::TickW-1:0]  r_echo_width, n_echo_width;
    logic [urs_pkg::DistW-1:0]  r_dist, n_dist;

    // Output register
    logic                       r_out_valid;
    logic                       r_trigger_level, n_trigger_level;
    logic                       r_updated, n_updated;
    logic                       r_no_echo, n_no_echo;

    logic                       w_accept;
    logic                       w_start;
    urs_pkg::t_phase            w_phase;
    logic [urs_pkg::TickW-1:0]  w_ticks;
    logic [urs_pkg::TickW-1:0]  w_ticks_inc;
    logic [urs_pkg::IntvW-1:0]  w_since;
    logic                       w_meas_done;
    logic                       w_timeout;
    logic [ProdW-1:0]           w_product;
    logic [urs_pkg::DistW-1:0]  w_sample;
    logic [urs_pkg::DistW:0]    w_sum;
    logic [urs_pkg::DistW-1:0]  w_avg;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // A new ranging cycle begins when idle and the interval has run out.
    assign w_start     = (r_phase == urs_pkg::PH_IDLE) && (r_since >= r_interval_us);
    assign w_phase     = w_start ? urs_pkg::PH_TRIG : r_phase;
    assign w_ticks     = w_start ? '0 : r_phase_ticks;
    assign w_since     = w_start ? '0 : r_since;
    assign w_ticks_inc = urs_pkg::sat_inc24(w_ticks);

    assign w_meas_done = (w_phase == urs_pkg::PH_MEASURE) && !i_echo_level;
    assign w_timeout   = !w_meas_done && (w_phase != urs_pkg::PH_IDLE)
                         && (w_phase != urs_pkg::PH_TRIG)
                         && (w_ticks_inc >= r_timeout_us);

    // Only a completed echo with a nonzero sample moves the distance; a timeout does not.
    assign w_product = ProdW'(r_echo_width) * ProdW'(r_scale_q16);
    assign w_sample  = (|w_product[ProdW-1:urs_pkg::DistW+16])
                       ? '1 : w_product[urs_pkg::DistW+15:16];
    assign w_sum     = {1'b0, r_dist} + {1'b0, w_sample};
    assign w_avg     = w_sum[urs_pkg::DistW:1];

    // Next-state logic
    always_comb begin
        n_phase       = w_phase;
        n_phase_ticks = w_ticks;
        n_echo_width  = r_echo_width;
        n_since       = (&w_since) ? w_since : w_since + urs_pkg::IntvW'(1);
        case (w_phase)
            urs_pkg::PH_IDLE: begin
            end
            urs_pkg::PH_TRIG: begin
                n_phase_ticks = w_ticks_inc;
                if (w_ticks_inc >= urs_pkg::TickW'(r_trigger_us)) begin
                    n_phase       = urs_pkg::PH_WAIT_LOW;
                    n_phase_ticks = '0;
                end
            end
            urs_pkg::PH_WAIT_LOW: begin
                n_phase_ticks = w_ticks_inc;
                if (!i_echo_level) begin
                    n_phase = urs_pkg::PH_WAIT_RISE;
                end
            end
            urs_pkg::PH_WAIT_RISE: begin
                n_phase_ticks = w_ticks_inc;
                if (i_echo_level) begin
                    n_phase      = urs_pkg::PH_MEASURE;
                    n_echo_width = urs_pkg::TickW'(1);
                end
            end
            urs_pkg::PH_MEASURE: begin
                n_phase_ticks = w_ticks_inc;
                if (i_echo_level) begin
                    n_echo_width = urs_pkg::sat_inc24(r_echo_width);
                end
            end
            default: begin
                n_phase       = urs_pkg::PH_IDLE;
                n_phase_ticks = '0;
            end
        endcase
        if (w_meas_done || w_timeout) begin
            n_phase       = urs_pkg::PH_IDLE;
            n_phase_ticks = '0;
            n_echo_width  = '0;
        end
    end

    // Output logic
    always_comb begin
        n_trigger_level = (w_phase == urs_pkg::PH_TRIG);
        n_no_echo       = w_timeout;
        n_dist          = r_dist;
        n_updated       = 1'b0;
        if (w_meas_done && (w_sample != '0)) begin
            n_dist    = w_avg;
            n_updated = (w_avg != r_dist);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_us  <= urs_pkg::TrigReset;
            r_interval_us <= urs_pkg::IntvReset;
            r_timeout_us  <= urs_pkg::TimeoutReset;
            r_scale_q16   <= urs_pkg::ScaleReset;
        end else if (i_cfg_we) begin
            case (urs_pkg::t_cfg_idx'(i_cfg_index))
                urs_pkg::CFG_TRIGGER:  r_trigger_us  <= i_cfg_data[urs_pkg::TrigW-1:0];
                urs_pkg::CFG_INTERVAL: r_interval_us <= i_cfg_data[urs_pkg::IntvW-1:0];
                urs_pkg::CFG_TIMEOUT:  r_timeout_us  <= i_cfg_data[urs_pkg::TickW-1:0];
                urs_pkg::CFG_SCALE:    r_scale_q16   <= i_cfg_data[urs_pkg::ScaleW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= urs_pkg::PH_IDLE;
            r_phase_ticks <= '0;
            r_since       <= '1;
            r_echo_width  <= '0;
            r_dist        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase       <= n_phase;
                r_phase_ticks <= n_phase_ticks;
                r_since       <= n_since;
                r_echo_width  <= n_echo_width;
                r_dist        <= n_dist;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_trigger_level <= n_trigger_level;
            r_updated       <= n_updated;
            r_no_echo       <= n_no_echo;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_trigger_level = r_trigger_level;
    assign o_distance_cm   = r_dist;
    assign o_updated       = r_updated;
    assign o_no_echo       = r_no_echo;

    `URS_ASSERT_SAME(a_measure_width, r_phase == urs_pkg::PH_MEASURE,
        r_echo_width != '0, "echo width is zero while measuring")
    `URS_ASSERT_SAME(a_upd_vs_timeout, r_out_valid,
        !(r_updated && r_no_echo), "update and timeout reported together")
    `URS_ASSERT_NEXT(a_upd_changes, w_accept && n_updated,
        r_dist != $past(r_dist), "update flagged without a distance change")
    `URS_ASSERT_NEXT(a_hold_state, !w_accept,
        $stable(r_phase) && $stable(r_dist) && $stable(r_since),
        "sequencer state moved without an input transfer")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the ultrasonic range sampler: directed ranging table, then random ticks.
module testbench;
    import urs_pkg::*;

    localparam int unsigned STUCK_LIMIT     = 2000;
    localparam int unsigned RANDOM_PHASES   = 8;
    localparam int unsigned TICKS_PER_PHASE = 130;
    localparam int unsigned SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic             trig;
        logic [DistW-1:0] dist_cm;
        logic             upd;
        logic             no_echo;
    } t_reading;

    typedef struct packed {
        logic            is_cfg;
        t_cfg_idx        idx;
        logic [CfgW-1:0] data;
        logic            echo;
        logic [31:0]     reps;
        logic            typed;
        t_reading        want;
    } t_ranging_step;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_echo_level = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_trigger_level;
    logic [DistW-1:0]    o_distance_cm;
    logic                o_updated;
    logic                o_no_echo;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = CFG_TRIGGER;
    logic [CfgW-1:0]     i_cfg_data = '0;

    ultrasonic_range_sampler uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_echo_level    (i_echo_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_trigger_level (o_trigger_level),
        .o_distance_cm   (o_distance_cm),
        .o_updated       (o_updated),
        .o_no_echo       (o_no_echo),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Register copies and sequencer state of the predictor.
    logic [TrigW-1:0]  cfg_trig;
    logic [IntvW-1:0]  cfg_intv;
    logic [TickW-1:0]  cfg_tmo;
    logic [ScaleW-1:0] cfg_scale;
    t_phase            seq_phase;
    logic [TickW-1:0]  seq_ticks;
    logic [IntvW-1:0]  since_trig;
    logic [TickW-1:0]  pulse_width;
    logic [DistW-1:0]  avg_dist;

    t_reading      expected_readings[$];
    t_ranging_step ranging_steps[$];

    // Echo pulse being played back by the random sensor.
    int unsigned pre_hi;
    int unsigned lo_len;
    int unsigned hi_len;

    bit quiet_send = 1'b0;
    bit quiet_recv = 1'b0;
    int unsigned stall_left = 0;
    int unsigned stuck = 0;

    int unsigned n_ticks = 0;
    int unsigned n_readings = 0;
    int unsigned n_timeouts = 0;
    int unsigned n_updates = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned n_mismatches = 0;

    t_reading seen;
    t_reading wanted;

    function automatic logic [TickW-1:0] tick_up(input logic [TickW-1:0] v);
        return (v == {TickW{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic t_reading predict_reading(input logic echo);
        t_reading               r;
        logic                   finished;
        logic [TickW-1:0]       w;
        logic [TickW+ScaleW-1:0] prod;
        logic [DistW-1:0]       sample;
        logic [DistW:0]         sum;
        r = '0;
        finished = 1'b0;
        w = '0;
        if (seq_phase == PH_IDLE && since_trig >= cfg_intv) begin
            seq_phase = PH_TRIG;
            seq_ticks = '0;
            since_trig = '0;
        end
        if (seq_phase == PH_TRIG) begin
            r.trig = 1'b1;
            seq_ticks = tick_up(seq_ticks);
            if (seq_ticks >= cfg_trig) begin
                seq_phase = PH_WAIT_LOW;
                seq_ticks = '0;
            end
        end else if (seq_phase != PH_IDLE) begin
            seq_ticks = tick_up(seq_ticks);
            case (seq_phase)
                PH_WAIT_LOW: begin
                    if (!echo) seq_phase = PH_WAIT_RISE;
                end
                PH_WAIT_RISE: begin
                    if (echo) begin
                        seq_phase = PH_MEASURE;
                        pulse_width = TickW'(1);
                    end
                end
                default: begin
                    if (echo) begin
                        pulse_width = tick_up(pulse_width);
                    end else begin
                        finished = 1'b1;
                        w = pulse_width;
                    end
                end
            endcase
            // A pulse that ends on the timeout tick still counts as a measurement.
            if (!finished && seq_ticks >= cfg_tmo) begin
                finished = 1'b1;
                w = '0;
                r.no_echo = 1'b1;
            end
            if (finished) begin
                prod = (TickW+ScaleW)'(w) * (TickW+ScaleW)'(cfg_scale);
                sample = (|prod[TickW+ScaleW-1:ScaleW+DistW]) ? {DistW{1'b1}}
                                                              : prod[ScaleW+DistW-1:ScaleW];
                if (sample != '0) begin
                    sum = {1'b0, avg_dist} + {1'b0, sample};
                    if (sum[DistW:1] != avg_dist) r.upd = 1'b1;
                    avg_dist = sum[DistW:1];
                end
                seq_phase = PH_IDLE;
                seq_ticks = '0;
                pulse_width = '0;
            end
        end
        if (since_trig != {IntvW{1'b1}}) since_trig = since_trig + 1'b1;
        r.dist_cm = avg_dist;
        return r;
    endfunction

    // Plays a plausible echo: a new pulse is armed on every trigger tick, sometimes
    // behind an echo still in progress, and a few ticks are flipped as noise.
    function automatic logic sensor_echo();
        logic e;
        if ((seq_phase == PH_IDLE && since_trig >= cfg_intv) || seq_phase == PH_TRIG) begin
            pre_hi = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            lo_len = $urandom_range(1, 6);
            hi_len = $urandom_range(1, cfg_tmo + 4);
            e = 1'($urandom_range(0, 1));
        end else if (pre_hi > 0) begin
            e = 1'b1;
            pre_hi--;
        end else if (lo_len > 0) begin
            e = 1'b0;
            lo_len--;
        end else if (hi_len > 0) begin
            e = 1'b1;
            hi_len--;
        end else begin
            e = 1'b0;
        end
        if ($urandom_range(0, 19) == 0) e = ~e;
        return e;
    endfunction

    function automatic int unsigned pick_pause(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void add_cfg(input t_cfg_idx idx, input logic [CfgW-1:0] data);
        t_ranging_step s;
        s = '0;
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.data = data;
        ranging_steps.push_back(s);
    endfunction

    function automatic void add_ticks(input logic echo, input int unsigned reps,
                                      input logic typed, input t_reading want);
        t_ranging_step s;
        s = '0;
        s.echo = echo;
        s.reps = reps;
        s.typed = typed;
        s.want = want;
        ranging_steps.push_back(s);
    endfunction

    // The expectation is queued before the transfer; the result cannot leave earlier.
    task automatic send_tick(input logic echo, input logic typed, input t_reading want);
        int unsigned gap;
        t_reading    r;
        gap = pick_pause(quiet_send);
        r = predict_reading(echo);
        expected_readings.push_back(typed ? want : r);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_echo_level <= echo;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_ticks++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgW-1:0] data);
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_TRIGGER:  cfg_trig = data[TrigW-1:0];
            CFG_INTERVAL: cfg_intv = data[IntvW-1:0];
            CFG_TIMEOUT:  cfg_tmo = data[TickW-1:0];
            default:      cfg_scale = data[ScaleW-1:0];
        endcase
        n_cfg_writes++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_trigger_level, o_distance_cm, o_updated, o_no_echo};
            n_readings++;
            if (seen.no_echo) n_timeouts++;
            if (seen.upd) n_updates++;
            if (expected_readings.size() == 0) begin
                n_mismatches++;
                if (n_mismatches <= SHOWN_MISMATCHES)
                    $display("Unexpected reading %0d: trig=%0b dist=%0d upd=%0b no_echo=%0b",
                             n_readings, seen.trig, seen.dist_cm, seen.upd, seen.no_echo);
            end else begin
                wanted = expected_readings.pop_front();
                if (seen.trig !== wanted.trig || seen.dist_cm !== wanted.dist_cm ||
                    seen.upd !== wanted.upd || seen.no_echo !== wanted.no_echo) begin
                    n_mismatches++;
                    if (n_mismatches <= SHOWN_MISMATCHES)
                        $display({"Reading %0d: expected trig=%0b dist=%0d upd=%0b no_echo=%0b,",
                                  " got trig=%0b dist=%0d upd=%0b no_echo=%0b"},
                                 n_readings, wanted.trig, wanted.dist_cm, wanted.upd,
                                 wanted.no_echo, seen.trig, seen.dist_cm, seen.upd,
                                 seen.no_echo);
                end
            end
        end
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            stall_left = pick_pause(quiet_recv);
        end
    end

    initial begin
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("Watchdog expired after %0d cycles without a transfer.", STUCK_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int unsigned     ph;
        int unsigned     n;
        int unsigned     v;
        bit              noisy;
        logic [CfgW-1:0] data;

        cfg_trig = TrigReset;
        cfg_intv = IntvReset;
        cfg_tmo = TimeoutReset;
        cfg_scale = ScaleReset;
        seq_phase = PH_IDLE;
        seq_ticks = '0;
        since_trig = {IntvW{1'b1}};
        pulse_width = '0;
        avg_dist = '0;
        pre_hi = 0;
        lo_len = 0;
        hi_len = 0;

        // Reset defaults: the interval counts as elapsed, so the first tick triggers.
        add_ticks(1'b0, 1, 1'b1, {1'b1, 16'd0, 1'b0, 1'b0});
        add_ticks(1'b1, 10, 1'b1, {1'b1, 16'd0, 1'b0, 1'b0});
        // Echo already high after the trigger is skipped, then a 200 tick pulse.
        add_ticks(1'b1, 5, 1'b1, {1'b0, 16'd0, 1'b0, 1'b0});
        add_ticks(1'b0, 3, 1'b1, {1'b0, 16'd0, 1'b0, 1'b0});
        add_ticks(1'b1, 200, 1'b1, {1'b0, 16'd0, 1'b0, 1'b0});
        add_ticks(1'b0, 1, 1'b1, {1'b0, 16'd1, 1'b1, 1'b0});
        // Zero trigger width, zero interval and zero timeout; the upper data bits are dropped.
        add_cfg(CFG_TRIGGER, 24'hFFFC00);
        add_cfg(CFG_INTERVAL, 24'hF00000);
        add_cfg(CFG_TIMEOUT, 24'h000000);
        add_cfg(CFG_SCALE, 24'hFFFFFF);
        add_ticks(1'b1, 1, 1'b1, {1'b1, 16'd1, 1'b0, 1'b0});
        add_ticks(1'b1, 1, 1'b1, {1'b0, 16'd1, 1'b0, 1'b1});
        add_ticks(1'b0, 1, 1'b1, {1'b1, 16'd1, 1'b0, 1'b0});
        add_ticks(1'b0, 1, 1'b1, {1'b0, 16'd1, 1'b0, 1'b1});
        // The pulse falls on the timeout tick; its sample rounds down to zero.
        add_cfg(CFG_TIMEOUT, 24'd3);
        add_ticks(1'b0, 1, 1'b1, {1'b1, 16'd1, 1'b0, 1'b0});
        add_ticks(1'b0, 1, 1'b1, {1'b0, 16'd1, 1'b0, 1'b0});
        add_ticks(1'b1, 1, 1'b1, {1'b0, 16'd1, 1'b0, 1'b0});
        add_ticks(1'b0, 1, 1'b1, {1'b0, 16'd1, 1'b0, 1'b0});
        // Longest timeout and full-scale factor: a 200 tick pulse scales to 199.
        add_cfg(CFG_TIMEOUT, 24'hFFFFFF);
        add_cfg(CFG_TRIGGER, 24'h000007);
        add_ticks(1'b0, 7, 1'b1, {1'b1, 16'd1, 1'b0, 1'b0});
        add_ticks(1'b0, 1, 1'b1, {1'b0, 16'd1, 1'b0, 1'b0});
        add_ticks(1'b1, 200, 1'b1, {1'b0, 16'd1, 1'b0, 1'b0});
        add_ticks(1'b0, 1, 1'b1, {1'b0, 16'd100, 1'b1, 1'b0});
        // Longest interval: the sequencer stays idle.
        add_cfg(CFG_INTERVAL, 24'h0FFFFF);
        add_ticks(1'b1, 40, 1'b1, {1'b0, 16'd100, 1'b0, 1'b0});
        add_ticks(1'b0, 10, 1'b1, {1'b0, 16'd100, 1'b0, 1'b0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (ranging_steps[k]) begin
            if (ranging_steps[k].is_cfg)
                write_reg(ranging_steps[k].idx, ranging_steps[k].data);
            else
                repeat (ranging_steps[k].reps)
                    send_tick(ranging_steps[k].echo, ranging_steps[k].typed,
                              ranging_steps[k].want);
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            quiet_send = ($urandom_range(0, 3) == 0);
            quiet_recv = ($urandom_range(0, 3) == 0);
            noisy = ($urandom_range(0, 5) == 0);

            case ($urandom_range(0, 5))
                0:       v = 0;
                1:       v = 1;
                default: v = $urandom_range(2, 16);
            endcase
            data = CfgW'($urandom);
            data[TrigW-1:0] = v[TrigW-1:0];
            write_reg(CFG_TRIGGER, data);

            v = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            data = CfgW'($urandom);
            data[IntvW-1:0] = v[IntvW-1:0];
            write_reg(CFG_INTERVAL, data);

            v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 80);
            write_reg(CFG_TIMEOUT, v[TickW-1:0]);

            case ($urandom_range(0, 7))
                0:       v = 0;
                1:       v = 65535;
                default: v = $urandom_range(0, 65535);
            endcase
            data = CfgW'($urandom);
            data[ScaleW-1:0] = v[ScaleW-1:0];
            write_reg(CFG_SCALE, data);

            for (n = 0; n < TICKS_PER_PHASE; n++)
                send_tick(noisy ? 1'($urandom_range(0, 1)) : sensor_echo(), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (expected_readings.size() != 0) begin
            $display("%0d expected readings never arrived.", expected_readings.size());
            n_mismatches += expected_readings.size();
        end
        $display("Sent %0d echo ticks under %0d register writes; checked %0d readings.",
                 n_ticks, n_cfg_writes, n_readings);
        $display("Seen %0d echo timeouts and %0d distance updates; %0d mismatches.",
                 n_timeouts, n_updates, n_mismatches);
        if (n_mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
